// ----- rtl/secg_pkg.sv -----
package secg_pkg;

    localparam int unsigned TABLE_POINTS = 256;
    localparam int unsigned IDX_W = $clog2(TABLE_POINTS);

    localparam int unsigned OFF_W = 14;
    localparam int unsigned Y_W   = OFF_W + IDX_W;
    localparam int unsigned RCP_W = 29;
    localparam int unsigned RCP_SH = 40;
    localparam int unsigned P_W   = Y_W + RCP_W;

    localparam logic [7:0]  BPM_RESET  = 8'd160;
    localparam logic [16:0] BEAT_SCALE = 17'd60000;
    localparam logic [31:0] WRAP_16    = 32'd5536;

    localparam logic [63:0] TP64    = 64'(TABLE_POINTS);
    localparam logic [63:0] TP_SQ   = TP64 * TP64;
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef enum logic [2:0] {
        SEG_NONE,
        SEG_P,
        SEG_Q,
        SEG_R,
        SEG_S,
        SEG_T
    } t_seg;

    typedef logic [TABLE_POINTS-1:0][31:0] t_tab;

    // x mod 60000 is preserved: 2^16 == 5536 (mod 60000)
    function automatic logic [31:0] fold_mod(input logic [31:0] x);
        return 32'(x[31:16]) * WRAP_16 + 32'(x[15:0]);
    endfunction

    // restoring divide, table build only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] sine_lobe_q30(input logic [63:0] k);
        logic [63:0] kk, x, x2, term, pos, neg;
        kk   = (k * 64'd2 > TP64) ? (TP64 - k) : k;
        x    = PI_Q30 * kk / TP64;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 64'd0;
        term = ((term * x2) >> 30) / 64'd6;   neg = neg + term;
        term = ((term * x2) >> 30) / 64'd20;  pos = pos + term;
        term = ((term * x2) >> 30) / 64'd42;  neg = neg + term;
        term = ((term * x2) >> 30) / 64'd72;  pos = pos + term;
        term = ((term * x2) >> 30) / 64'd110; neg = neg + term;
        term = ((term * x2) >> 30) / 64'd156; pos = pos + term;
        return (pos > neg) ? (pos - neg) : 64'd0;
    endfunction

    function automatic logic [63:0] gauss_q30(input logic [63:0] k, input logic [63:0] c);
        logic [63:0] d, z, e, term, r;
        d = (k * 64'd2 >= TP64) ? (k * 64'd2 - TP64) : (TP64 - k * 64'd2);
        z = c * d * d * (64'd1 << 26) / TP_SQ;
        e = Q30_ONE;
        term = Q30_ONE;
        term = ((term * z) >> 30) / 64'd1;  e = e + term;
        term = ((term * z) >> 30) / 64'd2;  e = e + term;
        term = ((term * z) >> 30) / 64'd3;  e = e + term;
        term = ((term * z) >> 30) / 64'd4;  e = e + term;
        term = ((term * z) >> 30) / 64'd5;  e = e + term;
        term = ((term * z) >> 30) / 64'd6;  e = e + term;
        term = ((term * z) >> 30) / 64'd7;  e = e + term;
        term = ((term * z) >> 30) / 64'd8;  e = e + term;
        term = ((term * z) >> 30) / 64'd9;  e = e + term;
        term = ((term * z) >> 30) / 64'd10; e = e + term;
        term = ((term * z) >> 30) / 64'd11; e = e + term;
        term = ((term * z) >> 30) / 64'd12; e = e + term;
        term = ((term * z) >> 30) / 64'd13; e = e + term;
        term = ((term * z) >> 30) / 64'd14; e = e + term;
        term = ((term * z) >> 30) / 64'd15; e = e + term;
        term = ((term * z) >> 30) / 64'd16; e = e + term;
        term = ((term * z) >> 30) / 64'd17; e = e + term;
        term = ((term * z) >> 30) / 64'd18; e = e + term;
        term = ((term * z) >> 30) / 64'd19; e = e + term;
        term = ((term * z) >> 30) / 64'd20; e = e + term;
        r = udiv64(Q30_ONE << 30, e);
        for (int i = 0; i < 4; i++) begin
            r = (r * r) >> 30;
        end
        return r;
    endfunction

    function automatic t_tab build_lobe();
        t_tab tab;
        for (int k = 0; k < TABLE_POINTS; k++) begin
            tab[k] = 32'(sine_lobe_q30(64'(k)));
        end
        return tab;
    endfunction

    function automatic t_tab build_gauss(input logic [63:0] c);
        t_tab tab;
        for (int k = 0; k < TABLE_POINTS; k++) begin
            tab[k] = 32'(gauss_q30(64'(k), c));
        end
        return tab;
    endfunction

    localparam t_tab LOBE_TAB  = build_lobe();
    localparam t_tab PWAVE_TAB = build_gauss(64'd10);
    localparam t_tab TWAVE_TAB = build_gauss(64'd5);

    localparam logic [RCP_W-1:0] RCP_P = RCP_W'((64'd1 << RCP_SH) / 64'd9000);
    localparam logic [RCP_W-1:0] RCP_Q = RCP_W'((64'd1 << RCP_SH) / 64'd3000);
    localparam logic [RCP_W-1:0] RCP_R = RCP_W'((64'd1 << RCP_SH) / 64'd4800);
    localparam logic [RCP_W-1:0] RCP_S = RCP_W'((64'd1 << RCP_SH) / 64'd4200);
    localparam logic [RCP_W-1:0] RCP_T = RCP_W'((64'd1 << RCP_SH) / 64'd15000);

    function automatic logic [OFF_W-1:0] seg_width(input t_seg seg);
        logic [OFF_W-1:0] w;
        unique case (seg)
            SEG_P:   w = OFF_W'(9000);
            SEG_Q:   w = OFF_W'(3000);
            SEG_R:   w = OFF_W'(4800);
            SEG_S:   w = OFF_W'(4200);
            default: w = OFF_W'(15000);
        endcase
        return w;
    endfunction

    function automatic logic [RCP_W-1:0] seg_recip(input t_seg seg);
        logic [RCP_W-1:0] r;
        unique case (seg)
            SEG_P:   r = RCP_P;
            SEG_Q:   r = RCP_Q;
            SEG_R:   r = RCP_R;
            SEG_S:   r = RCP_S;
            default: r = RCP_T;
        endcase
        return r;
    endfunction

    // amplitude times 16
    function automatic logic [14:0] seg_amp16(input t_seg seg);
        logic [14:0] a;
        unique case (seg)
            SEG_P:   a = 15'd2400;
            SEG_Q:   a = 15'd3200;
            SEG_R:   a = 15'd24000;
            SEG_S:   a = 15'd4800;
            SEG_T:   a = 15'd4000;
            default: a = 15'd0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/synthetic_ecg_sample_generator_unit.sv -----
// Synthetic ECG sample generator. Each input transfer carries a millisecond timestamp and a
// noise value; each output transfer carries one 12-bit signed ECG sample, in input order.
// The cardiac phase (time_ms * beats_per_minute) mod 60000 selects the P, Q, R, S or T wave,
// whose shape comes from Q30 tables built at elaboration; noise is added, the sum saturated
// to -2048..2047 and truncated toward zero. A written rate of 0 acts as 1. The datapath is an
// 11-stage pipeline followed by an output register with a one-entry skid: one sample per clock
// sustained while the output is not stalled. The user must write the heart rate through
// i_cfg_wr_en/i_cfg_wr_data only while the block is idle (the block does not enforce it); reset value is 160.
module synthetic_ecg_sample_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [31:0] time_ms, [47:32] noise_sample
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [11:0] ecg_sample, [15:12] zero
);
    import secg_pkg::*;

    localparam int unsigned NSTG = 11;

    logic [7:0]         r_bpm;
    logic [NSTG:1]      r_vld;
    logic signed [15:0] r_noise [1:NSTG-1];

    logic [24:0]        r1_a;
    logic [16:0]        r2_a;
    logic [23:0]        r3_x;
    logic [17:0]        r4_a;
    logic [15:0]        r5_ph;
    t_seg               r6_seg, r7_seg, r8_seg, r9_seg;
    logic [Y_W-1:0]     r6_y, r7_y;
    logic [P_W-1:0]     r7_prod;
    logic [IDX_W-1:0]   r8_q;
    logic               r8_ge;
    logic [31:0]        r9_shape;
    logic signed [16:0] r10_w;
    logic [11:0]        r11_res;

    logic               r_out_vld, r_skid_vld;
    logic [11:0]        r_out, r_skid;

    logic               en;
    logic               exit_vld;

    logic [31:0]        s1_a, s2_a, s4_a, s5_a;
    logic [16:0]        s3_tm17;
    logic [15:0]        s3_tm;
    logic [7:0]         s3_rate;
    logic [16:0]        s5_b;
    logic [15:0]        s5_ph;
    t_seg               s6_seg;
    logic [15:0]        s6_start;
    logic [OFF_W-1:0]   s6_off;
    logic [Y_W-1:0]     s8_qw, s8_rem;
    logic [IDX_W-1:0]   s8_q;
    logic [IDX_W:0]     s9_idx_f;
    logic [IDX_W-1:0]   s9_idx;
    logic [31:0]        s9_shape;
    logic [46:0]        s10_prod, s10_rnd;
    logic [15:0]        s10_mag;
    logic signed [16:0] s10_w;
    logic signed [19:0] s11_n16;
    logic signed [20:0] s11_v, s11_vt, s11_vs;
    logic [11:0]        s11_res;

    assign en              = !r_skid_vld;
    assign exit_vld        = en && r_vld[NSTG];
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {4'b0000, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpm <= BPM_RESET;
        end else if (i_cfg_wr_en) begin
            r_bpm <= i_cfg_wr_data;
        end
    end

    always_comb begin
        // time mod 60000
        s1_a    = fold_mod(fold_mod(i_s_axis_tdata[31:0]));
        s2_a    = fold_mod(fold_mod(fold_mod(32'(r1_a))));
        s3_tm17 = (r2_a >= BEAT_SCALE) ? (r2_a - BEAT_SCALE) : r2_a;
        s3_tm   = s3_tm17[15:0];
        s3_rate = (r_bpm == 8'd0) ? 8'd1 : r_bpm;
        // (time * rate) mod 60000
        s4_a    = fold_mod(fold_mod(32'(r3_x)));
        s5_a    = fold_mod(32'(r4_a));
        s5_b    = s5_a[16:0];
        s5_ph   = (s5_b >= BEAT_SCALE) ? 16'(s5_b - BEAT_SCALE) : s5_b[15:0];
    end

    always_comb begin
        priority if (r5_ph < 16'd9000) begin
            s6_seg = SEG_P;  s6_start = 16'd0;
        end else if (r5_ph < 16'd12000) begin
            s6_seg = SEG_Q;  s6_start = 16'd9000;
        end else if (r5_ph < 16'd16800) begin
            s6_seg = SEG_R;  s6_start = 16'd12000;
        end else if (r5_ph < 16'd21000) begin
            s6_seg = SEG_S;  s6_start = 16'd16800;
        end else if (r5_ph >= 16'd27000 && r5_ph < 16'd42000) begin
            s6_seg = SEG_T;  s6_start = 16'd27000;
        end else begin
            s6_seg = SEG_NONE; s6_start = r5_ph;
        end
        s6_off = OFF_W'(r5_ph - s6_start);
    end

    always_comb begin
        // reciprocal estimate is exact or one low
        s8_q    = r7_prod[RCP_SH +: IDX_W];
        s8_qw   = Y_W'(s8_q) * Y_W'(seg_width(r7_seg));
        s8_rem  = r7_y - s8_qw;
        s9_idx_f = (IDX_W + 1)'(r8_q) + (IDX_W + 1)'(r8_ge);
        s9_idx  = (s9_idx_f >= (IDX_W + 1)'(TABLE_POINTS)) ?
                  IDX_W'(TABLE_POINTS - 1) : s9_idx_f[IDX_W-1:0];
        unique case (r8_seg)
            SEG_P:   s9_shape = PWAVE_TAB[s9_idx];
            SEG_T:   s9_shape = TWAVE_TAB[s9_idx];
            default: s9_shape = LOBE_TAB[s9_idx];
        endcase
    end

    always_comb begin
        s10_prod = 47'(seg_amp16(r9_seg)) * 47'(r9_shape);
        s10_rnd  = (s10_prod + (47'd1 << 29)) >> 30;
        s10_mag  = s10_rnd[15:0];
        if (r9_seg == SEG_Q || r9_seg == SEG_S) begin
            s10_w = -$signed({1'b0, s10_mag});
        end else begin
            s10_w = $signed({1'b0, s10_mag});
        end

        s11_n16 = $signed({r_noise[NSTG-1], 4'b0000});
        s11_v   = 21'(r10_w) + 21'(s11_n16);
        s11_vt  = s11_v + (s11_v[20] ? 21'sd15 : 21'sd0);
        s11_vs  = s11_vt >>> 4;
        priority if (s11_v > 21'sd32752) begin
            s11_res = 12'h7FF;
        end else if (s11_v < -21'sd32768) begin
            s11_res = 12'h800;
        end else begin
            s11_res = s11_vs[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-1:1], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_noise[1] <= $signed(i_s_axis_tdata[47:32]);
            for (int i = 2; i < NSTG; i++) begin
                r_noise[i] <= r_noise[i-1];
            end
            r1_a     <= s1_a[24:0];
            r2_a     <= s2_a[16:0];
            r3_x     <= 24'(s3_tm) * 24'(s3_rate);
            r4_a     <= s4_a[17:0];
            r5_ph    <= s5_ph;
            r6_seg   <= s6_seg;
            r6_y     <= Y_W'(s6_off) * Y_W'(TABLE_POINTS);
            r7_seg   <= r6_seg;
            r7_y     <= r6_y;
            r7_prod  <= P_W'(r6_y) * P_W'(seg_recip(r6_seg));
            r8_seg   <= r7_seg;
            r8_q     <= s8_q;
            r8_ge    <= s8_rem >= Y_W'(seg_width(r7_seg));
            r9_seg   <= r8_seg;
            r9_shape <= s9_shape;
            r10_w    <= (r9_seg == SEG_NONE) ? 17'sd0 : s10_w;
            r11_res  <= s11_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_m_axis_tready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= exit_vld;
            end
        end else if (exit_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_m_axis_tready) begin
            r_out <= r_skid_vld ? r_skid : r11_res;
        end else if (exit_vld) begin
            r_skid <= r11_res;
        end
    end

endmodule

// ----- rtl/secg_checker.sv -----
module secg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);
    import secg_pkg::*;

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("not idle after reset");

    // input backpressure only with a sample waiting at the output
    a_bp_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with empty output");

    a_bp_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready && i_m_axis_tready |=> o_s_axis_tready)
        else $error("input stall not released after output transfer");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[15:12] == 4'b0000)
        else $error("output padding not zero");

endmodule

bind synthetic_ecg_sample_generator_unit secg_checker u_secg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
